/* src/itsolv_pkg.sv */
// Shared widths, constants and types for the intercept time solver.
// No dependencies; every other file in src imports this package.
package itsolv_pkg;

    localparam int IN_W         = 22;        // offsets and velocities
    localparam int SPD_W        = 16;        // projectile speed
    localparam int TIME_W       = 18;        // time, 16 fraction bits
    localparam int FRAC_W       = 16;
    localparam int LOW_W        = TIME_W - FRAC_W;
    localparam int P_W          = 2 * IN_W;  // one 22x22 product
    localparam int A_W          = 46;        // signed A and B
    localparam int MA_W         = 44;        // |A|
    localparam int MB_W         = 45;        // |B|
    localparam int C_W          = 44;        // C = O.O
    localparam int SS_SHIFT     = 8;         // S*S scaled to 8 fraction bits
    localparam int BL_W         = 23;        // low split of |B|
    localparam int AL_W         = 22;        // low split of |A| and C
    localparam int D_W          = 91;        // B*B, 4|A|C and the discriminant
    localparam int SQ_W         = 46;        // root width, one bit per stage
    localparam int SQ_IN_W      = 2 * SQ_W;
    localparam int RAD_SHIFT    = 24;        // fallback radicand C * 2^24
    localparam int NUM_W        = 47;
    localparam int DEN_W        = 46;
    localparam int FRONT_STAGES = 6;

    localparam logic [TIME_W-1:0]      MAX_TIME_RESET = TIME_W'(78643);
    localparam logic [MA_W-1:0]        A_SMALL_MAX    = MA_W'(2);
    localparam logic signed [A_W-1:0]  B_LIN_MAX      = A_W'(-3);

    // How the time is formed once the root is known.
    typedef enum logic [2:0] {
        MODE_LIN,    // C / |B|
        MODE_ADD,    // (|B| + r) / 2|A|
        MODE_RSUB,   // (r - |B|) / 2|A|
        MODE_BSUB,   // (|B| - r) / 2|A|
        MODE_FALL,   // sqrt(C * 2^24) / S
        MODE_SAT     // fallback with zero speed
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [MB_W-1:0]    bmag;
        logic [MA_W-1:0]    amag;
        logic [C_W-1:0]     c;
        logic [SPD_W-1:0]   speed;
    } side_t;

endpackage

/* src/itsolv_front.sv */
// Front end: products, quadratic coefficients, discriminant and root selection.
// Six register stages; depends on itsolv_pkg.
module itsolv_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    input  logic signed [itsolv_pkg::IN_W-1:0]   offset_x,
    input  logic signed [itsolv_pkg::IN_W-1:0]   offset_y,
    input  logic signed [itsolv_pkg::IN_W-1:0]   offset_z,
    input  logic signed [itsolv_pkg::IN_W-1:0]   vel_x,
    input  logic signed [itsolv_pkg::IN_W-1:0]   vel_y,
    input  logic signed [itsolv_pkg::IN_W-1:0]   vel_z,
    input  logic [itsolv_pkg::SPD_W-1:0]         proj_speed,
    output logic                                 rad_valid,
    output logic [itsolv_pkg::SQ_IN_W-1:0]       radicand,
    output itsolv_pkg::side_t                    side
);
    import itsolv_pkg::*;

    typedef struct packed {
        logic a_neg;
        logic a_small;
        logic b_pos;
        logic b_neg;
        logic b_lin;
        logic c_pos;
    } flg_t;

    localparam int BH_W = MB_W - BL_W;
    localparam int AH_W = MA_W - AL_W;

    logic signed [IN_W-1:0] o_in [3];
    logic signed [IN_W-1:0] v_in [3];

    assign o_in[0] = offset_x;
    assign o_in[1] = offset_y;
    assign o_in[2] = offset_z;
    assign v_in[0] = vel_x;
    assign v_in[1] = vel_y;
    assign v_in[2] = vel_z;

    // stage 1: products
    logic                   v1_reg;
    logic signed [P_W-1:0]  oo_reg [3];
    logic signed [P_W-1:0]  vv_reg [3];
    logic signed [P_W-1:0]  ov_reg [3];
    logic [2*SPD_W-1:0]     ss_reg;
    logic [SPD_W-1:0]       spd1_reg;

    // stage 2: coefficients
    logic                   v2_reg;
    logic signed [A_W-1:0]  a2_reg, b2_reg;
    logic [C_W-1:0]         c2_reg;
    logic [SPD_W-1:0]       spd2_reg;
    logic signed [A_W-1:0]  a_next, b_next, vsum, ovsum, osum;

    // stage 3: magnitudes and flags
    logic                   v3_reg;
    logic [MA_W-1:0]        amag3_reg;
    logic [MB_W-1:0]        bmag3_reg;
    logic [C_W-1:0]         c3_reg;
    logic [SPD_W-1:0]       spd3_reg;
    flg_t                   f3_reg;
    logic signed [A_W-1:0]  amag_next, bmag_next;
    flg_t                   f_next;

    // stage 4: partial products
    logic                   v4_reg;
    logic [2*BH_W-1:0]      hh_reg;
    logic [BH_W+BL_W-1:0]   hl_reg;
    logic [2*BL_W-1:0]      ll_reg;
    logic [2*AL_W-1:0]      ahch_reg, ahcl_reg, alch_reg, alcl_reg;
    logic [MA_W-1:0]        amag4_reg;
    logic [MB_W-1:0]        bmag4_reg;
    logic [C_W-1:0]         c4_reg;
    logic [SPD_W-1:0]       spd4_reg;
    flg_t                   f4_reg;

    // stage 5: B*B and 4|A|C
    logic                   v5_reg;
    logic [D_W-1:0]         bsq5_reg, pac5_reg;
    logic [MA_W-1:0]        amag5_reg;
    logic [MB_W-1:0]        bmag5_reg;
    logic [C_W-1:0]         c5_reg;
    logic [SPD_W-1:0]       spd5_reg;
    flg_t                   f5_reg;
    logic [D_W-1:0]         bsq_next, pac_next;

    // stage 6: root selection
    logic                   v6_reg;
    logic [SQ_IN_W-1:0]     rad6_reg;
    side_t                  side6_reg;
    logic [SQ_IN_W-1:0]     rad_next;
    mode_t                  mode_next, fall_mode;
    logic [D_W-1:0]         disc;
    logic                   pac_le;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= req_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            oo_reg[i] <= o_in[i] * o_in[i];
            vv_reg[i] <= v_in[i] * v_in[i];
            ov_reg[i] <= o_in[i] * v_in[i];
        end
        ss_reg   <= proj_speed * proj_speed;
        spd1_reg <= proj_speed;
    end

    always_comb
    begin
        vsum  = A_W'(vv_reg[0]) + A_W'(vv_reg[1]) + A_W'(vv_reg[2]);
        osum  = A_W'(oo_reg[0]) + A_W'(oo_reg[1]) + A_W'(oo_reg[2]);
        ovsum = A_W'(ov_reg[0]) + A_W'(ov_reg[1]) + A_W'(ov_reg[2]);
        a_next = vsum - $signed(A_W'(ss_reg) << SS_SHIFT);
        b_next = ovsum <<< 1;
    end

    always_ff @(posedge clk)
    begin
        a2_reg   <= a_next;
        b2_reg   <= b_next;
        c2_reg   <= osum[C_W-1:0];
        spd2_reg <= spd1_reg;
    end

    always_comb
    begin
        amag_next     = a2_reg[A_W-1] ? -a2_reg : a2_reg;
        bmag_next     = b2_reg[A_W-1] ? -b2_reg : b2_reg;
        f_next.a_neg   = a2_reg[A_W-1];
        f_next.a_small = amag_next[MA_W-1:0] <= A_SMALL_MAX;
        f_next.b_pos   = !b2_reg[A_W-1] && (b2_reg != '0);
        f_next.b_neg   = b2_reg[A_W-1];
        f_next.b_lin   = b2_reg <= B_LIN_MAX;
        f_next.c_pos   = c2_reg != '0;
    end

    always_ff @(posedge clk)
    begin
        amag3_reg <= amag_next[MA_W-1:0];
        bmag3_reg <= bmag_next[MB_W-1:0];
        c3_reg    <= c2_reg;
        spd3_reg  <= spd2_reg;
        f3_reg    <= f_next;
    end

    always_ff @(posedge clk)
    begin
        hh_reg    <= bmag3_reg[MB_W-1:BL_W] * bmag3_reg[MB_W-1:BL_W];
        hl_reg    <= bmag3_reg[MB_W-1:BL_W] * bmag3_reg[BL_W-1:0];
        ll_reg    <= bmag3_reg[BL_W-1:0] * bmag3_reg[BL_W-1:0];
        ahch_reg  <= amag3_reg[MA_W-1:AL_W] * c3_reg[C_W-1:AL_W];
        ahcl_reg  <= amag3_reg[MA_W-1:AL_W] * c3_reg[AL_W-1:0];
        alch_reg  <= amag3_reg[AL_W-1:0] * c3_reg[C_W-1:AL_W];
        alcl_reg  <= amag3_reg[AL_W-1:0] * c3_reg[AL_W-1:0];
        amag4_reg <= amag3_reg;
        bmag4_reg <= bmag3_reg;
        c4_reg    <= c3_reg;
        spd4_reg  <= spd3_reg;
        f4_reg    <= f3_reg;
    end

    always_comb
    begin
        bsq_next = (D_W'(hh_reg) << (2 * BL_W)) + (D_W'(hl_reg) << (BL_W + 1))
                 + D_W'(ll_reg);
        pac_next = ((D_W'(ahch_reg) << (2 * AL_W)) + (D_W'(ahcl_reg) << AL_W)
                 + (D_W'(alch_reg) << AL_W) + D_W'(alcl_reg)) << 2;
    end

    always_ff @(posedge clk)
    begin
        bsq5_reg  <= bsq_next;
        pac5_reg  <= pac_next;
        amag5_reg <= amag4_reg;
        bmag5_reg <= bmag4_reg;
        c5_reg    <= c4_reg;
        spd5_reg  <= spd4_reg;
        f5_reg    <= f4_reg;
    end

    always_comb
    begin
        pac_le    = pac5_reg <= bsq5_reg;
        disc      = f5_reg.a_neg ? bsq5_reg + pac5_reg : bsq5_reg - pac5_reg;
        fall_mode = (spd5_reg == '0) ? MODE_SAT : MODE_FALL;
        if (f5_reg.a_small)
            mode_next = f5_reg.b_lin ? MODE_LIN : fall_mode;
        else if (f5_reg.a_neg)
        begin
            if (f5_reg.b_pos || f5_reg.c_pos)
                mode_next = f5_reg.b_pos ? MODE_ADD : MODE_RSUB;
            else
                mode_next = fall_mode;
        end
        else if (f5_reg.b_neg && pac_le)
            mode_next = f5_reg.c_pos ? MODE_BSUB : MODE_ADD;
        else
            mode_next = fall_mode;

        case (mode_next)
            MODE_ADD, MODE_RSUB, MODE_BSUB: rad_next = SQ_IN_W'(disc);
            MODE_FALL:                      rad_next = SQ_IN_W'(c5_reg) << RAD_SHIFT;
            default:                        rad_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rad6_reg        <= rad_next;
        side6_reg.mode  <= mode_next;
        side6_reg.bmag  <= bmag5_reg;
        side6_reg.amag  <= amag5_reg;
        side6_reg.c     <= c5_reg;
        side6_reg.speed <= spd5_reg;
    end

    assign rad_valid = v6_reg;
    assign radicand  = rad6_reg;
    assign side      = side6_reg;

endmodule

/* src/itsolv_sqrt.sv */
// Pipelined integer square root, one root bit per register stage.
// Carries the selection sideband alongside; depends on itsolv_pkg.
module itsolv_sqrt (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rad_valid,
    input  logic [itsolv_pkg::SQ_IN_W-1:0]  radicand,
    input  itsolv_pkg::side_t               side_in,
    output logic                            root_valid,
    output logic [itsolv_pkg::SQ_W-1:0]     root,
    output itsolv_pkg::side_t               side_out
);
    import itsolv_pkg::*;

    localparam int REM_W = SQ_W + 4;

    logic                v_reg    [SQ_W];
    logic [SQ_W-1:0]     root_reg [SQ_W];
    logic [REM_W-1:0]    rem_reg  [SQ_W];
    logic [SQ_IN_W-1:0]  rad_reg  [SQ_W];
    side_t               side_reg [SQ_W];

    for (genvar i = 0; i < SQ_W; i++)
    begin : g_step
        localparam int K = SQ_W - 1 - i;

        logic               v_in;
        logic [SQ_W-1:0]    q_in;
        logic [REM_W-1:0]   r_in, r_sh, trial;
        logic [SQ_IN_W-1:0] x_in;
        side_t              s_in;
        logic               take;
        logic [SQ_W-1:0]    root_next;
        logic [REM_W-1:0]   rem_next;

        if (i == 0)
        begin : g_first
            assign v_in = rad_valid;
            assign q_in = '0;
            assign r_in = '0;
            assign x_in = radicand;
            assign s_in = side_in;
        end
        else
        begin : g_rest
            assign v_in = v_reg[i-1];
            assign q_in = root_reg[i-1];
            assign r_in = rem_reg[i-1];
            assign x_in = rad_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        // bring down the next two radicand bits, try root bit one
        assign r_sh      = {r_in[REM_W-3:0], x_in[2*K+1 -: 2]};
        assign trial     = REM_W'({q_in, 2'b01});
        assign take      = r_sh >= trial;
        assign rem_next  = take ? r_sh - trial : r_sh;
        assign root_next = {q_in[SQ_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            root_reg[i] <= root_next;
            rem_reg[i]  <= rem_next;
            rad_reg[i]  <= x_in;
            side_reg[i] <= s_in;
        end
    end

    assign root_valid = v_reg[SQ_W-1];
    assign root       = root_reg[SQ_W-1];
    assign side_out   = side_reg[SQ_W-1];

endmodule

/* src/itsolv_div.sv */
// Pipelined restoring divider: floor(num * 2^16 / den) with overflow past 18 bits.
// One quotient bit per stage after a range check stage; depends on itsolv_pkg.
module itsolv_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic [itsolv_pkg::NUM_W-1:0]   num,
    input  logic [itsolv_pkg::DEN_W-1:0]   den,
    input  logic                           sat,
    output logic                           quo_valid,
    output logic [itsolv_pkg::TIME_W-1:0]  quot,
    output logic                           ovf
);
    import itsolv_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int CMP_W = DEN_W + LOW_W;

    logic               v0_reg;
    logic [REM_W-1:0]   rem0_reg;
    logic [DEN_W-1:0]   den0_reg;
    logic [LOW_W-1:0]   low0_reg;
    logic               ovf0_reg;

    logic               v_reg   [TIME_W];
    logic [REM_W-1:0]   rem_reg [TIME_W];
    logic [DEN_W-1:0]   den_reg [TIME_W];
    logic [LOW_W-1:0]   low_reg [TIME_W];
    logic [TIME_W-1:0]  q_reg   [TIME_W];
    logic               ovf_reg [TIME_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else
            v0_reg <= req_valid;
    end

    // a quotient of 2^18 or more cannot fit: flag it and let it clamp
    always_ff @(posedge clk)
    begin
        ovf0_reg <= sat || (CMP_W'(num) >= (CMP_W'(den) << LOW_W));
        rem0_reg <= REM_W'(num >> LOW_W);
        low0_reg <= num[LOW_W-1:0];
        den0_reg <= den;
    end

    for (genvar j = 0; j < TIME_W; j++)
    begin : g_step
        localparam int XB = TIME_W - 1 - j;

        logic               v_in, o_in, bit_in, take;
        logic [REM_W-1:0]   r_in, r_sh, rem_next;
        logic [DEN_W-1:0]   d_in;
        logic [LOW_W-1:0]   l_in;
        logic [TIME_W-1:0]  q_in, q_next;

        if (j == 0)
        begin : g_first
            assign v_in = v0_reg;
            assign r_in = rem0_reg;
            assign d_in = den0_reg;
            assign l_in = low0_reg;
            assign q_in = '0;
            assign o_in = ovf0_reg;
        end
        else
        begin : g_rest
            assign v_in = v_reg[j-1];
            assign r_in = rem_reg[j-1];
            assign d_in = den_reg[j-1];
            assign l_in = low_reg[j-1];
            assign q_in = q_reg[j-1];
            assign o_in = ovf_reg[j-1];
        end

        if (XB >= FRAC_W)
        begin : g_low
            assign bit_in = l_in[XB-FRAC_W];
        end
        else
        begin : g_zero
            assign bit_in = 1'b0;
        end

        assign r_sh     = {r_in[REM_W-2:0], bit_in};
        assign take     = r_sh >= REM_W'(d_in);
        assign rem_next = take ? r_sh - REM_W'(d_in) : r_sh;
        assign q_next   = {q_in[TIME_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            den_reg[j] <= d_in;
            low_reg[j] <= l_in;
            q_reg[j]   <= q_next;
            ovf_reg[j] <= o_in;
        end
    end

    assign quo_valid = v_reg[TIME_W-1];
    assign quot      = q_reg[TIME_W-1];
    assign ovf       = ovf_reg[TIME_W-1];

endmodule

/* src/intercept_time_solver_core.sv */
// Intercept time solver: earliest t > 0 with |offset + vel*t| = speed*t, clamped.
// One request per cycle; a request accepted with start gives one done pulse at the end of the pipeline.
// The pipeline never stalls, so busy stays low; the 46 square root stages make up most of the depth.
// Reset (rst_n low, asynchronous) drops everything in flight and sets max_time to 1.2 s.
// Depends on itsolv_pkg, itsolv_front, itsolv_sqrt and itsolv_div.
module intercept_time_solver_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 cfg_we,
    input  logic [itsolv_pkg::TIME_W-1:0]        cfg_wdata,
    input  logic signed [itsolv_pkg::IN_W-1:0]   offset_x,
    input  logic signed [itsolv_pkg::IN_W-1:0]   offset_y,
    input  logic signed [itsolv_pkg::IN_W-1:0]   offset_z,
    input  logic signed [itsolv_pkg::IN_W-1:0]   vel_x,
    input  logic signed [itsolv_pkg::IN_W-1:0]   vel_y,
    input  logic signed [itsolv_pkg::IN_W-1:0]   vel_z,
    input  logic [itsolv_pkg::SPD_W-1:0]         proj_speed,
    output logic                                 done,
    output logic [itsolv_pkg::TIME_W-1:0]        hit_time,
    output logic                                 was_clamped
);
    import itsolv_pkg::*;

    // front, root, numerator stage, divider with its range check, output stage
    localparam int LAT = FRONT_STAGES + SQ_W + 1 + (TIME_W + 1) + 1;

    logic [TIME_W-1:0]  max_time_reg;

    logic               rad_valid;
    logic [SQ_IN_W-1:0] radicand;
    side_t              rad_side;

    logic               root_valid;
    logic [SQ_W-1:0]    root;
    side_t              root_side;

    logic               nd_v_reg;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic               sat_reg, sat_next;

    logic               quo_valid;
    logic [TIME_W-1:0]  quot;
    logic               ovf;

    logic               done_reg;
    logic [TIME_W-1:0]  hit_time_reg;
    logic               was_clamped_reg;

    // Nothing holds a request back: every cycle can take a new one.
    assign busy = 1'b0;

    // Horizon register; the user must write it only while no request is in flight (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_time_reg <= MAX_TIME_RESET;
        else if (cfg_we)
            max_time_reg <= cfg_wdata;
    end

    // Coefficients, discriminant and choice of root (six stages).
    itsolv_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (start),
        .offset_x   (offset_x),
        .offset_y   (offset_y),
        .offset_z   (offset_z),
        .vel_x      (vel_x),
        .vel_y      (vel_y),
        .vel_z      (vel_z),
        .proj_speed (proj_speed),
        .rad_valid  (rad_valid),
        .radicand   (radicand),
        .side       (rad_side)
    );

    // Square root of the discriminant, or of C * 2^24 for the distance fallback.
    itsolv_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .rad_valid  (rad_valid),
        .radicand   (radicand),
        .side_in    (rad_side),
        .root_valid (root_valid),
        .root       (root),
        .side_out   (root_side)
    );

    // Form the division. All time quotients are num * 2^16 / den; the
    // distance fallback scales speed by 2^16 so it fits the same form.
    always_comb
    begin
        num_next = '0;
        den_next = '0;
        sat_next = 1'b0;
        case (root_side.mode)
            MODE_LIN:
            begin
                num_next = NUM_W'(root_side.c);
                den_next = DEN_W'(root_side.bmag);
            end
            MODE_ADD:
            begin
                num_next = NUM_W'(root_side.bmag) + NUM_W'(root);
                den_next = DEN_W'(root_side.amag) << 1;
            end
            MODE_RSUB:
            begin
                num_next = NUM_W'(root) - NUM_W'(root_side.bmag);
                den_next = DEN_W'(root_side.amag) << 1;
            end
            MODE_BSUB:
            begin
                num_next = NUM_W'(root_side.bmag) - NUM_W'(root);
                den_next = DEN_W'(root_side.amag) << 1;
            end
            MODE_FALL:
            begin
                num_next = NUM_W'(root);
                den_next = DEN_W'(root_side.speed) << FRAC_W;
            end
            default:
            begin
                sat_next = 1'b1;   // zero speed: time saturates
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nd_v_reg <= 1'b0;
        else
            nd_v_reg <= root_valid;
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        sat_reg <= sat_next;
    end

    itsolv_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (nd_v_reg),
        .num        (num_reg),
        .den        (den_reg),
        .sat        (sat_reg),
        .quo_valid  (quo_valid),
        .quot       (quot),
        .ovf        (ovf)
    );

    // Clamp to the horizon and present the result for exactly one cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= quo_valid;
    end

    always_ff @(posedge clk)
    begin
        if (ovf || (quot > max_time_reg))
        begin
            hit_time_reg    <= max_time_reg;
            was_clamped_reg <= 1'b1;
        end
        else
        begin
            hit_time_reg    <= quot;
            was_clamped_reg <= 1'b0;
        end
    end

    assign done        = done_reg;
    assign hit_time    = hit_time_reg;
    assign was_clamped = was_clamped_reg;

    // A clamped result carries the horizon itself, an unclamped one does not exceed it.
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (was_clamped ? (hit_time == max_time_reg) : (hit_time <= max_time_reg)))
        else $error("hit_time disagrees with the clamp flag");

    // Every accepted request comes out after the fixed pipeline depth.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request lost in the pipeline");

    // No result appears without a request at the matching cycle.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without a request");

endmodule
